>>> rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and constants of the tilt-to-servo-angle core.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int unsigned CordicSteps    = 16;
  localparam int unsigned AngleFracScale = 100;
  localparam int unsigned AtanTabLen     = 24;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 16;
  localparam int unsigned InDataW        = 56;
  localparam int unsigned OutDataW       = 48;

  localparam logic [CfgIdxW-1:0] RegFilterWeight = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDeadband     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFaultLimit   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPulseMin     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegPulseSpan    = 3'd4;

  // atan(2^-i) in degrees * 65536
  function automatic logic [21:0] atan_lut(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // classified sample handed from front to back
  typedef struct packed {
    logic               fault;
    logic               sreset;
    logic               mode;
    logic               remote_valid;
    logic [7:0]         remote_angle;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } item_t;

  typedef struct packed {
    logic [8:0]  filter_weight;
    logic [9:0]  deadband;
    logic [3:0]  fault_limit;
    logic [11:0] pulse_min;
    logic [11:0] pulse_span;
  } cfg_t;

endpackage

>>> rtl/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front
// Accepts samples, flags bus faults, tracks fault count and mode.
// ----------------------------------------------------------------------------
module tts_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tts_pkg::InDataW-1:0]   in_data_i,
  input  logic [1:0]                    in_user_i,
  input  logic [3:0]                    fault_limit_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output tts_pkg::item_t                q_item_o
);

  logic       mode_q, mode_d;
  logic [3:0] cnt_q, cnt_d;
  logic       bad, sreset, mode_new;
  logic [4:0] n;
  logic [15:0] rx, ry, rz;

  assign in_ready_o = q_ready_i;
  assign q_valid_o  = in_valid_i;

  assign rx = in_data_i[15:0];
  assign ry = in_data_i[31:16];
  assign rz = in_data_i[47:32];

  always_comb begin
    bad      = ((rx == 16'h0) && (ry == 16'h0) && (rz == 16'h0)) ||
               ((rx == 16'hFFFF) && (ry == 16'hFFFF) && (rz == 16'hFFFF));
    mode_new = mode_q ^ in_user_i[0];
    n        = {1'b0, cnt_q} + 5'd1;
    sreset   = bad && (n > {1'b0, fault_limit_i});
    if (!bad || sreset) begin
      cnt_d = 4'd0;
    end else begin
      cnt_d = n[3:0];
    end
    mode_d = mode_new;
    q_item_o.fault        = bad;
    q_item_o.sreset       = sreset;
    q_item_o.mode         = mode_new;
    q_item_o.remote_valid = in_user_i[1];
    q_item_o.remote_angle = in_data_i[55:48];
    q_item_o.ax           = rx;
    q_item_o.ay           = ry;
    q_item_o.az           = rz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else if (in_valid_i && q_ready_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> rtl/tts_queue.sv
// ----------------------------------------------------------------------------
// tts_queue
// Two-entry queue of classified samples between front and back.
// ----------------------------------------------------------------------------
module tts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  tts_pkg::item_t wr_item_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output tts_pkg::item_t rd_item_o
);

  tts_pkg::item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

>>> rtl/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back
// Square root, CORDIC vectoring, low-pass, target select, deadband, pulse.
// ----------------------------------------------------------------------------
module tts_back #(
  parameter int unsigned CORDIC_STEPS     = tts_pkg::CordicSteps,
  parameter int unsigned ANGLE_FRAC_SCALE = tts_pkg::AngleFracScale
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_ready_o,
  input  tts_pkg::item_t               q_item_i,
  input  tts_pkg::cfg_t                cfg_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tts_pkg::OutDataW-1:0] out_data_o
);

  localparam int unsigned Full  = 180 * ANGLE_FRAC_SCALE;
  localparam int unsigned Lim   = 90 * ANGLE_FRAC_SCALE;
  localparam int unsigned AW    = $clog2(Full + 1) + 1;  // signed angle width
  localparam int unsigned SW    = AW + 1;
  localparam int unsigned StepW = 5;
  // divide by Full as a multiply by a rounded-up reciprocal; exact while the
  // product of target and span stays below Full * 4096
  localparam int unsigned DivShift = 2 * $clog2(Full) + 12;
  localparam logic [63:0] DivRecip =
    ((64'd1 << DivShift) + 64'(Full) - 64'd1) / 64'(Full);

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_CORDIC, S_SCALE, S_FILT, S_TGT, S_PULSE, S_OUT
  } state_e;

  state_e state_q;
  tts_pkg::item_t it_q;
  logic [33:0] rem_q;
  logic [16:0] root_q;
  logic [4:0]  sq_i_q;
  logic signed [27:0] xc_q, yc_q;
  logic signed [31:0] z_q;
  logic [StepW-1:0] ci_q;
  logic signed [SW-1:0] smooth_q, pitch_q;
  logic [7:0] remote_q;
  logic [AW-1:0] last_q, tgt_q;
  logic has_sent_q, upd_q, busy_tag_q;
  logic [31:0] prod_q;
  logic [12:0] pulse_q;

  // per-step signals
  logic [33:0] sq_sum;
  logic signed [27:0] dx, dy;
  logic signed [31:0] zsc_full;
  logic signed [47:0] zmul;
  logic signed [SW-1:0] u_clamp;
  logic signed [47:0] u_raw;
  logic [8:0]  w;
  logic signed [SW+10:0] facc;
  logic signed [SW+1:0] tsum;
  logic [AW-1:0] tgt_new;
  logic [AW:0]   diff;
  logic [7:0]    ra;
  logic [63:0]   qmul;

  assign q_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    sq_sum  = 34'(unsigned'(32'(it_q.ay * it_q.ay))) + 34'(unsigned'(32'(it_q.az * it_q.az)));
    dx = yc_q >>> ci_q;
    dy = xc_q >>> ci_q;
    zmul = 48'(z_q) * 48'(signed'(ANGLE_FRAC_SCALE)) + 48'sd32768;
    u_raw = zmul >>> 16;
    zsc_full = 32'(u_raw);
    if (u_raw > 48'(signed'(Lim))) u_clamp = SW'(signed'(Lim));
    else if (u_raw < -48'(signed'(Lim))) u_clamp = -SW'(signed'(Lim));
    else u_clamp = SW'(zsc_full);
    w = (cfg_i.filter_weight > 9'd256) ? 9'd256 : cfg_i.filter_weight;
    facc = (SW+11)'(signed'({1'b0, w})) * (SW+11)'(pitch_q)
         + (SW+11)'(signed'(10'd256 - {1'b0, w})) * (SW+11)'(smooth_q)
         + (SW+11)'(128);
    ra = (it_q.remote_angle > 8'd180) ? 8'd180 : it_q.remote_angle;
    tsum = (SW+2)'(smooth_q) + (SW+2)'(signed'(Lim));
    if (!it_q.mode) begin
      tgt_new = AW'(remote_q * ANGLE_FRAC_SCALE);
    end else if (tsum < 0) begin
      tgt_new = '0;
    end else if (tsum > (SW+2)'(signed'(Full))) begin
      tgt_new = AW'(Full);
    end else begin
      tgt_new = AW'(tsum);
    end
    diff = (tgt_q >= last_q) ? {1'b0, tgt_q - last_q} : {1'b0, last_q - tgt_q};
    qmul = 64'(prod_q) * DivRecip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      smooth_q   <= '0;
      remote_q   <= '0;
      last_q     <= '0;
      has_sent_q <= 1'b0;
      upd_q      <= 1'b0;
      busy_tag_q <= 1'b0;
      ci_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            it_q    <= q_item_i;
            sq_i_q  <= 5'd0;
            root_q  <= '0;
            rem_q   <= '0;
            pitch_q <= '0;
            state_q <= q_item_i.fault ? S_TGT : S_SQRT;
          end
        end
        S_SQRT: begin
          // one root bit per cycle: bring down two bits of the square
          begin : sqrt_step
            logic [35:0] r2;
            logic [35:0] t2;
            r2 = {rem_q, 2'b00} | 36'(sq_sum[33 - 2*sq_i_q -: 2]);
            t2 = {17'd0, root_q, 2'b01};
            if (r2 >= t2) begin
              rem_q  <= 34'(r2 - t2);
              root_q <= {root_q[15:0], 1'b1};
            end else begin
              rem_q  <= 34'(r2);
              root_q <= {root_q[15:0], 1'b0};
            end
          end
          if (sq_i_q == 5'd16) begin
            state_q <= S_CORDIC;
          end
          sq_i_q <= sq_i_q + 5'd1;
        end
        S_CORDIC: begin
          if (ci_q == '0 && !busy_tag_q) begin
            xc_q <= 28'(root_q) <<< 8;
            yc_q <= -(28'(it_q.ax) <<< 8);
            z_q  <= '0;
            busy_tag_q <= 1'b1;
          end else begin
            if (yc_q >= 0) begin
              xc_q <= xc_q + dx; yc_q <= yc_q - dy;
              z_q  <= z_q + 32'(tts_pkg::atan_lut(ci_q));
            end else begin
              xc_q <= xc_q - dx; yc_q <= yc_q + dy;
              z_q  <= z_q - 32'(tts_pkg::atan_lut(ci_q));
            end
            if (32'(ci_q) == CORDIC_STEPS - 1) begin
              ci_q <= '0;
              busy_tag_q <= 1'b0;
              state_q <= S_SCALE;
            end else begin
              ci_q <= ci_q + 1'b1;
            end
          end
        end
        S_SCALE: begin
          pitch_q <= u_clamp;
          state_q <= S_FILT;
        end
        S_FILT: begin
          smooth_q <= SW'(facc >>> 8);
          state_q  <= S_TGT;
        end
        S_TGT: begin
          if (it_q.remote_valid) remote_q <= ra;
          it_q.remote_valid <= 1'b0;
          state_q <= S_PULSE;
          if (!it_q.remote_valid) begin
            tgt_q <= tgt_new;
            prod_q <= 32'(tgt_new) * 32'(cfg_i.pulse_span);
          end else begin
            state_q <= S_TGT;
          end
        end
        S_PULSE: begin
          pulse_q <= 13'(cfg_i.pulse_min) + 13'(qmul >> DivShift);
          if (!has_sent_q || diff > (AW+1)'(cfg_i.deadband)) begin
            upd_q      <= 1'b1;
            last_q     <= tgt_q;
            has_sent_q <= 1'b1;
          end else begin
            upd_q <= 1'b0;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_data_o = {1'b0, it_q.mode, it_q.sreset, it_q.fault,
                       15'(smooth_q), pulse_q, 15'(tgt_q), upd_q};

endmodule

>>> rtl/tilt_to_servo_angle_core.sv
// ----------------------------------------------------------------------------
// tilt_to_servo_angle_core
// Accelerometer tilt to servo angle with low-pass and deadband.
// ----------------------------------------------------------------------------
// Usage: samples enter on s_axis (tdata = x, y, z, remote angle from bit 0;
// tuser = mode toggle, remote valid). Each sample gives one result on m_axis.
// A front stage checks for bus faults and tracks mode and fault count, then
// passes the sample through a two-entry queue to the back end, which takes a
// bit-serial square root, a CORDIC vectoring pass and the filter, target and
// pulse math. A sample that carries a remote angle first latches that angle
// in the target step and then repeats the step; a faulted one skips the
// square root, CORDIC and filter steps.
// One item is in the back end at a time; the front keeps accepting while the
// queue has room, and the back end takes the next request the cycle after a
// result leaves.
// The result register holds while m_axis_tready is low, stalling the back end.
// Reset clears mode, counts, filter state and loads default registers.
// Configuration writes go on cfg_valid_i / cfg_index_i / cfg_data_i.
// ----------------------------------------------------------------------------
module tilt_to_servo_angle_core #(
  parameter int unsigned CORDIC_STEPS     = tts_pkg::CordicSteps,
  parameter int unsigned ANGLE_FRAC_SCALE = tts_pkg::AngleFracScale
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], remote_angle[55:48]
  input  logic [tts_pkg::InDataW-1:0]   s_axis_tdata,
  // mode_toggle[0], remote_valid[1]
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // servo_update[0], servo_angle_centi[15:1], pulse_width_us[28:16],
  // pitch_centi[43:29], sample_fault[44], sensor_reset[45], tilt_mode[46]
  output logic [tts_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tts_pkg::CfgDataW-1:0]  cfg_data_i
);

  tts_pkg::cfg_t  cfg_q;
  tts_pkg::item_t f_item, b_item;
  logic f_valid, f_ready, b_valid, b_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_weight <= 9'd102;
      cfg_q.deadband      <= 10'd30;
      cfg_q.fault_limit   <= 4'd5;
      cfg_q.pulse_min     <= 12'd500;
      cfg_q.pulse_span    <= 12'd2000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tts_pkg::RegFilterWeight: cfg_q.filter_weight <= cfg_data_i[8:0];
        tts_pkg::RegDeadband:     cfg_q.deadband      <= cfg_data_i[9:0];
        tts_pkg::RegFaultLimit:   cfg_q.fault_limit   <= cfg_data_i[3:0];
        tts_pkg::RegPulseMin:     cfg_q.pulse_min     <= cfg_data_i[11:0];
        tts_pkg::RegPulseSpan:    cfg_q.pulse_span    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  tts_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata), .in_user_i(s_axis_tuser),
    .fault_limit_i(cfg_q.fault_limit),
    .q_valid_o(f_valid), .q_ready_i(f_ready), .q_item_o(f_item)
  );

  tts_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_ready_o(f_ready), .wr_item_i(f_item),
    .rd_valid_o(b_valid), .rd_ready_i(b_ready), .rd_item_o(b_item)
  );

  tts_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_FRAC_SCALE(ANGLE_FRAC_SCALE)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(b_valid), .q_ready_o(b_ready), .q_item_i(b_item),
    .cfg_i(cfg_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );

endmodule

>>> tb/tts_checker.sv
// ----------------------------------------------------------------------------
// tts_checker
// Watches the sample, result and register channels of the tilt-to-servo core,
// predicts each result from its own copy of the core state and compares it
// field by field with what comes out.
// ----------------------------------------------------------------------------
module tts_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [tts_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [tts_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [tts_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tts_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // highest field first, so servo_update lands in bit 0
  typedef struct packed {
    logic        mode;
    logic        sreset;
    logic        fault;
    logic [14:0] pitch;
    logic [12:0] pulse;
    logic [14:0] angle;
    logic        update;
  } servo_cmd_t;

  localparam longint FullScale = 180 * longint'(tts_pkg::AngleFracScale);
  localparam longint AtanDeg[tts_pkg::AtanTabLen] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  tts_pkg::cfg_t regs;
  logic       mode_q;
  int         fault_run;
  int         smooth_q;
  int         remote_q;
  int         last_angle;
  logic       sent_once;
  servo_cmd_t expected_cmds[$];

  assign pending_o = expected_cmds.size();

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint tilt_pitch(longint ax, longint ay, longint az);
    longint xc, yc, z, dx, dy, u, lim, scale;
    scale = longint'(tts_pkg::AngleFracScale);
    xc = root_floor(ay * ay + az * az) * 256;
    yc = -ax * 256;
    z = 0;
    lim = 90 * scale;
    for (int i = 0; i < int'(tts_pkg::CordicSteps) && i < int'(tts_pkg::AtanTabLen); i++) begin
      dx = yc >>> i;
      dy = xc >>> i;
      if (yc >= 0) begin
        xc += dx; yc -= dy; z += AtanDeg[i];
      end else begin
        xc -= dx; yc += dy; z -= AtanDeg[i];
      end
    end
    u = (z * scale + 32768) >>> 16;
    if (u > lim) u = lim;
    if (u < -lim) u = -lim;
    return u;
  endfunction

  function automatic servo_cmd_t servo_step(logic [tts_pkg::InDataW-1:0] d, logic [1:0] u);
    servo_cmd_t c;
    logic [15:0] rx, ry, rz;
    longint w, tgt, diff, scale;
    c = '0;
    scale = longint'(tts_pkg::AngleFracScale);
    rx = d[15:0];
    ry = d[31:16];
    rz = d[47:32];
    if (u[0]) mode_q = ~mode_q;
    if ((rx == 16'h0 && ry == 16'h0 && rz == 16'h0) ||
        (rx == 16'hFFFF && ry == 16'hFFFF && rz == 16'hFFFF)) begin
      c.fault = 1'b1;
      if (fault_run + 1 > int'(regs.fault_limit)) begin
        c.sreset = 1'b1;
        fault_run = 0;
      end else begin
        fault_run = (fault_run + 1) & 15;
      end
    end else begin
      w = (regs.filter_weight > 9'd256) ? 256 : longint'(regs.filter_weight);
      fault_run = 0;
      smooth_q = int'((w * tilt_pitch(longint'($signed(rx)), longint'($signed(ry)),
                                       longint'($signed(rz)))
                       + (256 - w) * smooth_q + 128) >>> 8);
    end
    if (u[1]) remote_q = (d[55:48] > 8'd180) ? 180 : int'(d[55:48]);
    if (!mode_q) begin
      tgt = longint'(remote_q) * scale;
    end else begin
      tgt = longint'(smooth_q) + 90 * scale;
      if (tgt < 0) tgt = 0;
      if (tgt > FullScale) tgt = FullScale;
    end
    diff = tgt - last_angle;
    if (diff < 0) diff = -diff;
    if (!sent_once || diff > longint'(regs.deadband)) begin
      c.update = 1'b1;
      last_angle = int'(tgt);
      sent_once = 1'b1;
    end
    c.angle = tgt[14:0];
    c.pulse = 13'(longint'(regs.pulse_min) + tgt * longint'(regs.pulse_span) / FullScale);
    c.pitch = 15'(smooth_q);
    c.mode = mode_q;
    return c;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    servo_cmd_t e, a;
    if (!rst_ni) begin
      regs <= '{filter_weight: 9'd102, deadband: 10'd30, fault_limit: 4'd5,
                pulse_min: 12'd500, pulse_span: 12'd2000};
      mode_q = 1'b0;
      fault_run = 0;
      smooth_q = 0;
      remote_q = 0;
      last_angle = 0;
      sent_once = 1'b0;
      expected_cmds.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tts_pkg::RegFilterWeight: regs.filter_weight <= cfg_data_i[8:0];
          tts_pkg::RegDeadband:     regs.deadband      <= cfg_data_i[9:0];
          tts_pkg::RegFaultLimit:   regs.fault_limit   <= cfg_data_i[3:0];
          tts_pkg::RegPulseMin:     regs.pulse_min     <= cfg_data_i[11:0];
          tts_pkg::RegPulseSpan:    regs.pulse_span    <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_cmds.push_back(servo_step(s_axis_tdata, s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        a = m_axis_tdata[46:0];
        if (expected_cmds.size() == 0) begin
          $error("result with nothing expected: %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          e = expected_cmds.pop_front();
          check_field("servo_update", e.update, a.update);
          check_field("servo_angle_centi", e.angle, a.angle);
          check_field("pulse_width_us", e.pulse, a.pulse);
          check_field("pitch_centi", longint'($signed(e.pitch)), longint'($signed(a.pitch)));
          check_field("sample_fault", e.fault, a.fault);
          check_field("sensor_reset", e.sreset, a.sreset);
          check_field("tilt_mode", e.mode, a.mode);
        end
      end
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the tilt-to-servo core: directed corner samples, then random
// sample streams under several register settings, most with random idling on
// both sides; the checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [tts_pkg::CfgDataW-1:0] cfg_data_t;

  localparam int StallLimit = 20000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [tts_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]                   s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [tts_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [tts_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  cfg_data_t                    cfg_data_i = '0;
  int                           fail_count;
  int                           pending;
  int                           quiet_cycles = 0;
  bit                           no_idle = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  tilt_to_servo_angle_core dut (.*);

  tts_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side backpressure
  always @(posedge clk_i)
    m_axis_tready <= no_idle || ($urandom_range(99) >= 11);

  // abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic toggle, logic rvalid, logic [7:0] angle);
    if (!no_idle && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 30) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {angle, z, y, x};
    s_axis_tuser  <= {rvalid, toggle};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // hold off samples until every result is back, then write one register
  task automatic write_reg(logic [tts_pkg::CfgIdxW-1:0] idx, cfg_data_t val);
    s_axis_tvalid <= 1'b0;
    // let the last accepted request reach the checker first
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(int w, int db, int lim, int pmin, int pspan);
    write_reg(tts_pkg::RegFilterWeight, cfg_data_t'(w));
    write_reg(tts_pkg::RegDeadband, cfg_data_t'(db));
    write_reg(tts_pkg::RegFaultLimit, cfg_data_t'(lim));
    write_reg(tts_pkg::RegPulseMin, cfg_data_t'(pmin));
    write_reg(tts_pkg::RegPulseSpan, cfg_data_t'(pspan));
  endtask

  task automatic random_samples(int n);
    logic [15:0] x, y, z;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        x = 16'h0; y = 16'h0; z = 16'h0;
      end else if (r < 8) begin
        x = 16'hFFFF; y = 16'hFFFF; z = 16'hFFFF;
      end else if (r < 25) begin
        x = 16'($signed($urandom_range(2000)) - 1000);
        y = 16'($signed($urandom_range(2000)) - 1000);
        z = 16'($signed($urandom_range(2000)) - 1000);
      end else begin
        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
      end
      send_sample(x, y, z, $urandom_range(99) < 10, $urandom_range(99) < 30,
                  8'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: faults past the default limit, axis extremes, remote clamps
    for (int i = 0; i < 7; i++)
      send_sample(i[0] ? 16'hFFFF : 16'h0, i[0] ? 16'hFFFF : 16'h0,
                  i[0] ? 16'hFFFF : 16'h0, 1'b0, 1'b0, 8'd0);
    send_sample(16'h0, 16'h0, 16'hFFFF, 1'b0, 1'b1, 8'd180);
    send_sample(16'h8000, 16'h0, 16'h0, 1'b0, 1'b1, 8'd181);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 8'd255);
    send_sample(16'h0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 8'd3);
    send_sample(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 8'd0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 8'd0);
    send_sample(16'h8000, 16'h0, 16'h1, 1'b0, 1'b0, 8'd0);
    send_sample(16'h7FFF, 16'h1, 16'h0, 1'b0, 1'b0, 8'd0);
    send_sample(16'h0001, 16'h0, 16'h0, 1'b1, 1'b1, 8'd90);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFE, 1'b0, 1'b0, 8'd0);

    set_regs(0, 0, 0, 0, 0);
    send_sample(16'h0, 16'h0, 16'h0, 1'b1, 1'b0, 8'd0);
    random_samples(150);
    set_regs(256, 1000, 15, 4095, 4095);
    random_samples(200);
    no_idle = 1'b1;
    set_regs(511, 1023, 1, 12, 4095);
    random_samples(200);
    no_idle = 1'b0;
    set_regs(102, 30, 5, 500, 2000);
    random_samples(250);
    set_regs($urandom_range(256), $urandom_range(1000), $urandom_range(15),
             $urandom_range(4095), $urandom_range(4095));
    random_samples(200);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/tts_pkg.sv
rtl/tts_front.sv
rtl/tts_queue.sv
rtl/tts_back.sv
rtl/tilt_to_servo_angle_core.sv
tb/tts_checker.sv
tb/tb_top.sv
